/* sv/three_phase_gate_pattern_timer_core_assert.svh */
// ---------------------------------------------------------------------------
// Three-phase gate pattern timer assertion macros
// Shared concurrent assertion forms used by the timer core.
// ---------------------------------------------------------------------------
`ifndef THREE_PHASE_GATE_PATTERN_TIMER_CORE_ASSERT_SVH
`define THREE_PHASE_GATE_PATTERN_TIMER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPGPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPGPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tpgpt_pkg.sv */
// ---------------------------------------------------------------------------
// Three-phase gate pattern timer package
// State word layout, pattern constants and the gate pattern function.
// ---------------------------------------------------------------------------
package tpgpt_pkg;

  localparam int unsigned IdxW     = 11;
  localparam int unsigned GateW    = 6;
  localparam int unsigned CntW     = 8;
  localparam int unsigned AngleW   = 9;

  localparam logic [IdxW-1:0] PatternLen = 11'd1440;
  localparam logic [IdxW-1:0] PatternLast = 11'd1439;

  localparam logic [GateW-1:0] GateUh  = 6'b000001;
  localparam logic [GateW-1:0] GateUl  = 6'b000010;
  localparam logic [GateW-1:0] GateVh  = 6'b000100;
  localparam logic [GateW-1:0] GateVl  = 6'b001000;
  localparam logic [GateW-1:0] GateWh  = 6'b010000;
  localparam logic [GateW-1:0] GateWl  = 6'b100000;
  localparam logic [GateW-1:0] GateAll = 6'b111111;

  localparam logic [CntW-1:0] CompareReset = 8'd1;

  // One word of timer state, held in the state memory.
  typedef struct packed {
    logic [CntW-1:0]  tick_count;
    logic [IdxW-1:0]  pattern_index;
    logic [GateW-1:0] gate_latch;
  } state_t;

  localparam state_t StateReset = '{tick_count: '0, pattern_index: '0, gate_latch: '0};

  // Minimum interval mask for an angle step.
  function automatic logic [GateW-1:0] mask_min(input logic [AngleW-1:0] c);
    logic [GateW-1:0] m;
    m = '0;
    if (c inside {[9'd1:9'd179]})   m |= GateUh;
    if (c inside {[9'd181:9'd359]}) m |= GateUl;
    if (c inside {[9'd121:9'd299]}) m |= GateVh;
    if (c < 9'd120 || c > 9'd300)   m |= GateVl;
    if (c inside {[9'd61:9'd239]})  m |= GateWh;
    if (c < 9'd60 || c > 9'd240)    m |= GateWl;
    return m;
  endfunction

  // Middle interval mask for an angle step.
  function automatic logic [GateW-1:0] mask_mid(input logic [AngleW-1:0] c);
    logic [GateW-1:0] m;
    m = '0;
    if (c inside {[9'd31:9'd60], [9'd120:9'd149]})  m |= GateUh;
    if (c inside {[9'd211:9'd240], [9'd300:9'd329]}) m |= GateUl;
    if (c inside {[9'd151:9'd180], [9'd240:9'd269]}) m |= GateVh;
    if (c inside {[9'd61:9'd90], [9'd330:9'd358]})   m |= GateVl;
    if (c inside {[9'd91:9'd120], [9'd180:9'd209]})  m |= GateWh;
    if (c inside {[9'd1:9'd30], [9'd270:9'd299]})    m |= GateWl;
    return m;
  endfunction

  // Maximum interval mask for an angle step.
  function automatic logic [GateW-1:0] mask_max(input logic [AngleW-1:0] c);
    logic [GateW-1:0] m;
    m = '0;
    if (c inside {[9'd61:9'd119]})  m |= GateUh;
    if (c inside {[9'd241:9'd299]}) m |= GateUl;
    if (c inside {[9'd181:9'd239]}) m |= GateVh;
    if (c inside {[9'd1:9'd59]})    m |= GateVl;
    if (c inside {[9'd121:9'd179]}) m |= GateWh;
    if (c inside {[9'd301:9'd359]}) m |= GateWl;
    return m;
  endfunction

  // Gate pattern for an index below the pattern length: the upper bits give
  // the angle step and the two low bits the slot within it.
  function automatic logic [GateW-1:0] pattern_at(input logic [IdxW-1:0] idx);
    logic [AngleW-1:0] c;
    logic [1:0]        p;
    logic [GateW-1:0]  m;
    c = idx[IdxW-1:2];
    p = idx[1:0];
    m = '0;
    if (p < 2'd2) m |= mask_min(c) | mask_mid(c);
    if (p < 2'd3) m |= mask_max(c);
    return m & GateAll;
  endfunction

endpackage

/* sv/three_phase_gate_pattern_timer_core.sv */
// Latency: a result is held in the output register the cycle after its input transfer.
// Throughput: one tick per cycle while the result is drained, set by the single read-modify-write
//   of the state word, with the last written word forwarded past the registered memory read.
// Reset: asynchronous, active low; the state word reads as all zero through a valid
//   bit, the compare value returns to 1 and no result is pending.
// ---------------------------------------------------------------------------
// Three-phase gate pattern timer core
// Compare counter that steps a computed six-gate pattern on every match.
// ---------------------------------------------------------------------------
`include "three_phase_gate_pattern_timer_core_assert.svh"

module three_phase_gate_pattern_timer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // Tick input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       over_temp_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [5:0] gate_bits_o,
  output logic       sync_pulse_o
);

  tpgpt_pkg::state_t state_mem [1];
  tpgpt_pkg::state_t rd_q;
  tpgpt_pkg::state_t wr_data_q, wr_data_d;
  tpgpt_pkg::state_t cur_state;
  tpgpt_pkg::state_t next_state;
  logic              state_valid_q;
  logic              fwd_q;
  logic              wr_en;

  logic [tpgpt_pkg::CntW-1:0]  compare_q;
  logic [tpgpt_pkg::IdxW-1:0]  idx_use;
  logic [tpgpt_pkg::IdxW-1:0]  idx_inc;
  logic [tpgpt_pkg::GateW-1:0] gate_new;
  logic                        match;
  logic                        sync_new;
  logic                        in_xfer;

  logic                        out_valid_q;
  logic [tpgpt_pkg::GateW-1:0] gate_q;
  logic                        sync_q;

  // A new tick is taken whenever the output register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Current state: reset value until first written, else forwarded or read word.
  always_comb begin
    if (!state_valid_q) begin
      cur_state = tpgpt_pkg::StateReset;
    end else if (fwd_q) begin
      cur_state = wr_data_q;
    end else begin
      cur_state = rd_q;
    end
  end

  // Tick update: count up, or on a match latch the pattern and advance the index; over-temperature clears the gates.
  always_comb begin
    match    = cur_state.tick_count >= compare_q;
    idx_use  = (cur_state.pattern_index < tpgpt_pkg::PatternLen) ?
               cur_state.pattern_index : '0;
    idx_inc  = idx_use + 11'd1;
    sync_new = 1'b0;
    next_state = cur_state;
    if (match) begin
      next_state.tick_count = '0;
      next_state.gate_latch = over_temp_i ? '0 : tpgpt_pkg::pattern_at(idx_use);
      if (idx_inc >= tpgpt_pkg::PatternLen) begin
        next_state.pattern_index = '0;
        sync_new = 1'b1;
      end else begin
        next_state.pattern_index = idx_inc;
      end
    end else begin
      next_state.tick_count = cur_state.tick_count + 8'd1;
    end
    if (over_temp_i) begin
      next_state.gate_latch = '0;
    end
    gate_new = next_state.gate_latch;
  end

  // Write-back selection: a configuration write restarts the counter.
  always_comb begin
    wr_en     = cfg_we_i || in_xfer;
    wr_data_d = next_state;
    if (cfg_we_i) begin
      wr_data_d            = cur_state;
      wr_data_d.tick_count = '0;
    end
  end

  // State memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      state_mem[0] <= wr_data_d;
    end
    rd_q <= state_mem[0];
  end

  // Forwarding copy of the last written word.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wr_data_q <= wr_data_d;
    end
  end

  // Memory control and compare register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_valid_q <= 1'b0;
      fwd_q         <= 1'b0;
      compare_q     <= tpgpt_pkg::CompareReset;
    end else begin
      fwd_q <= wr_en;
      if (wr_en) begin
        state_valid_q <= 1'b1;
      end
      if (cfg_we_i) begin
        compare_q <= cfg_wdata_i;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      gate_q <= gate_new;
      sync_q <= sync_new;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gate_bits_o  = gate_q;
  assign sync_pulse_o = sync_q;

  // The last pattern position is a dead slot, so a wrap always shows gates off.
  `TPGPT_ASSERT_SAME(a_sync_gates_off, clk_i, rst_ni, out_valid_q && sync_q, gate_q == '0, "sync result with gates on")

  // An over-temperature tick forces the delivered gates low.
  `TPGPT_ASSERT_NEXT(a_hot_gates_off, clk_i, rst_ni, in_xfer && over_temp_i, out_valid_q && gate_q == '0, "gates on after over-temperature")

  // The stored pattern index never leaves the pattern range.
  `TPGPT_ASSERT_SAME(a_index_range, clk_i, rst_ni, state_valid_q, cur_state.pattern_index <= tpgpt_pkg::PatternLast, "pattern index out of range")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Three-phase gate pattern timer testbench
// Drives timer ticks with random over-temperature flags and random idle gaps
// on both channels, predicts the gate bits and sync pulse of every tick in a
// scoreboard class, and sweeps the compare value through its extremes.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxGap     = 19;
  localparam int unsigned LongStall  = 150;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 100;

  // One expected result: latched gates and the wrap pulse.
  typedef struct packed {
    logic [tpgpt_pkg::GateW-1:0] gates;
    logic                        sync;
  } gate_result_t;

  // Tracks the timer state and holds the gate words still to be seen.
  class gate_timer_tracker;
    logic [tpgpt_pkg::CntW-1:0]  cmp_value;
    logic [tpgpt_pkg::CntW-1:0]  tick_cnt;
    logic [tpgpt_pkg::IdxW-1:0]  pat_idx;
    logic [tpgpt_pkg::GateW-1:0] gate_reg;
    gate_result_t                expected_q[$];
    int unsigned                 mismatches;
    int unsigned                 ticks;
    int unsigned                 hot_ticks;
    int unsigned                 wraps;
    int unsigned                 writes;

    function new();
      cmp_value  = tpgpt_pkg::CompareReset;
      tick_cnt   = '0;
      pat_idx    = '0;
      gate_reg   = '0;
      mismatches = 0;
      ticks      = 0;
      hot_ticks  = 0;
      wraps      = 0;
      writes     = 0;
    endfunction

    // A new compare value restarts the counter.
    function void write_compare(input logic [tpgpt_pkg::CntW-1:0] value);
      cmp_value = value;
      tick_cnt  = '0;
      writes++;
    endfunction

    // Gate word for one position: angle step in the upper bits, slot in the
    // two low bits. Bits are {WL, WH, VL, VH, UL, UH}.
    function logic [tpgpt_pkg::GateW-1:0] gate_pattern(input logic [tpgpt_pkg::IdxW-1:0] idx);
      int unsigned                 a;
      logic [1:0]                  slot;
      logic [tpgpt_pkg::GateW-1:0] lo_m;
      logic [tpgpt_pkg::GateW-1:0] mid_m;
      logic [tpgpt_pkg::GateW-1:0] hi_m;
      logic [tpgpt_pkg::GateW-1:0] word;
      a    = 32'(idx[tpgpt_pkg::IdxW-1:2]);
      slot = idx[1:0];
      lo_m = {a < 60 || a > 240, a > 60 && a < 240, a < 120 || a > 300,
              a > 120 && a < 300, a > 180 && a < 360, a > 0 && a < 180};
      mid_m = {(a > 0 && a <= 30) || (a >= 270 && a < 300),
               (a > 90 && a <= 120) || (a >= 180 && a < 210),
               (a > 60 && a <= 90) || (a >= 330 && a < 359),
               (a > 150 && a <= 180) || (a >= 240 && a < 270),
               (a > 210 && a <= 240) || (a >= 300 && a < 330),
               (a > 30 && a <= 60) || (a >= 120 && a < 150)};
      hi_m = {a > 300 && a < 360, a > 120 && a < 180, a > 0 && a < 60,
              a > 180 && a < 240, a > 240 && a < 300, a > 60 && a < 120};
      word = '0;
      if (slot < 2'd2) word |= lo_m | mid_m;
      if (slot < 2'd3) word |= hi_m;
      return word;
    endfunction

    // Advance the timer by one accepted tick and queue its result.
    function void note_tick(input logic hot);
      logic [tpgpt_pkg::IdxW-1:0] idx;
      logic                       sync;
      sync = 1'b0;
      ticks++;
      if (hot) hot_ticks++;
      if (tick_cnt >= cmp_value) begin
        tick_cnt = '0;
        idx      = (pat_idx < tpgpt_pkg::PatternLen) ? pat_idx : '0;
        gate_reg = hot ? '0 : gate_pattern(idx);
        idx      = idx + 1'b1;
        if (idx >= tpgpt_pkg::PatternLen) begin
          idx  = '0;
          sync = 1'b1;
          wraps++;
        end
        pat_idx = idx;
      end else begin
        tick_cnt = tick_cnt + 1'b1;
      end
      // Over-temperature clears the gates on any tick.
      if (hot) gate_reg = '0;
      expected_q.push_back('{gates: gate_reg, sync: sync});
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(input logic [tpgpt_pkg::GateW-1:0] gates, input logic sync);
      gate_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, gates %b sync %b", $time, gates, sync);
        return;
      end
      exp_r = expected_q.pop_front();
      if (gates !== exp_r.gates) begin
        mismatches++;
        $display("%0t: gate_bits expected %b actual %b", $time, exp_r.gates, gates);
      end
      if (sync !== exp_r.sync) begin
        mismatches++;
        $display("%0t: sync_pulse expected %b actual %b", $time, exp_r.sync, sync);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [tpgpt_pkg::CntW-1:0]  cfg_wdata_i = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic                        over_temp_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [tpgpt_pkg::GateW-1:0] gate_bits_o;
  logic                        sync_pulse_o;

  gate_timer_tracker tracker = new();
  bit                burst_mode    = 1'b0;
  bit                stall_request = 1'b0;

  three_phase_gate_pattern_timer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .over_temp_i (over_temp_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .gate_bits_o (gate_bits_o),
    .sync_pulse_o(sync_pulse_o)
  );

  // Clock generation.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Offer one tick after a random gap and hold it until the transfer.
  task automatic send_tick(input logic hot);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    over_temp_i <= hot;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_tick(hot);
  endtask

  // Send n ticks, the over-temperature flag of tick i taken from bit i.
  task automatic send_ticks(input int unsigned n, input logic [31:0] hot_bits);
    for (int unsigned i = 0; i < n; i++) send_tick(hot_bits[i]);
  endtask

  // Write the compare value once the timer has drained.
  task automatic change_compare(input logic [tpgpt_pkg::CntW-1:0] value);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    tracker.write_compare(value);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random ready gaps, one long hold-off on request.
  initial begin
    int unsigned gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, MaxGap);
      if (stall_request) begin
        stall_request = 1'b0;
        gap           = LongStall;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_result(gate_bits_o, sync_pulse_o);
    end
  end

  // Stimulus sequence.
  initial begin
    logic [tpgpt_pkg::CntW-1:0] cmp;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset compare value of one: a match every second tick.
    send_ticks(5, 32'b00100);
    // Compare value zero: every tick matches, over-temperature in between.
    change_compare(8'd0);
    send_ticks(6, 32'b010010);
    // Lower the compare value while the counter is part way up.
    change_compare(8'd5);
    send_ticks(3, 32'b000);
    change_compare(8'd2);
    send_ticks(4, 32'b0000);
    // Largest compare value.
    change_compare(8'd255);
    send_ticks(3, 32'b010);

    // Random phases over a spread of compare values and idle patterns.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph % 5)
        0: begin
          cmp = 8'd0;
        end
        1: begin
          cmp = (ph == 1) ? 8'd255 : 8'($urandom_range(128, 255));
        end
        2: begin
          cmp = 8'($urandom_range(1, 3));
        end
        3: begin
          cmp = 8'($urandom_range(0, 255));
        end
        default: begin
          cmp = 8'($urandom_range(4, 15));
        end
      endcase
      burst_mode = (ph % 3 == 2);
      change_compare(cmp);
      // Hold the result side off while ticks keep coming, to back up the input.
      if (ph == 5) stall_request = 1'b1;
      repeat (PhaseItems) send_tick($urandom_range(0, 7) == 0);
    end

    // Finish with a full-rate burst at compare value zero, then random gaps.
    burst_mode = 1'b1;
    change_compare(8'd0);
    repeat (10) send_tick($urandom_range(0, 15) == 0);
    burst_mode = 1'b0;
    repeat (20) send_tick($urandom_range(0, 3) == 0);

    // Drain and let any stray result show up.
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d ticks (%0d over-temperature) across %0d compare writes.",
             tracker.ticks, tracker.hot_ticks, tracker.writes);
    $display("The pattern index wrapped %0d times; %0d mismatches were found.",
             tracker.wraps, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding.", tracker.pending());
    $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/tpgpt_pkg.sv
sv/three_phase_gate_pattern_timer_core.sv
bench/tb_top.sv
